### src/upd_pkg.sv
// Package with shared types, constants and helpers for the URL percent decoder.
package upd_pkg;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 16;
  localparam int unsigned NibbleW = 4;

  localparam logic [ByteW-1:0] CharPercent = 8'h25;
  localparam logic [ByteW-1:0] CharPlus = 8'h2B;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [LenW-1:0] LenMax = 16'hFFFF;

  typedef enum logic [1:0] {
    PhaseIdle = 2'd0,
    PhasePercent = 2'd1,
    PhaseDigit = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic last;
    logic [LenW-1:0] length;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t [MaxResults-1:0] res;
  } decode_t;

  function automatic logic [NibbleW:0] hex_value(input logic [ByteW-1:0] c);
    logic [NibbleW:0] r;
    r = '0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, NibbleW'(c - 8'h30)};
      [8'h41:8'h46]: r = {1'b1, NibbleW'(c - 8'h37)};
      [8'h61:8'h66]: r = {1'b1, NibbleW'(c - 8'h57)};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [LenW-1:0] sat_inc(input logic [LenW-1:0] c);
    return (c == LenMax) ? c : c + LenW'(1);
  endfunction

endpackage

### src/upd_decode.sv
// Escape state machine that turns one registered byte into up to three results.
module upd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output upd_pkg::decode_t    dec_o
);
  import upd_pkg::*;

  phase_e phase_q, phase_d, phase_mid;
  logic [ByteW-1:0] held_char_q, held_char_d;
  logic [NibbleW-1:0] held_nib_q, held_nib_d;
  logic [LenW-1:0] count_q, count_d;
  logic [NibbleW:0] hex;
  logic hv;
  logic plain;

  assign hex = hex_value(byte_i);
  assign hv = hex[NibbleW];

  always_comb begin
    phase_mid = PhaseIdle;
    plain = 1'b1;
    unique case (phase_q)
      PhaseDigit: begin
        plain = !hv;
      end
      PhasePercent: begin
        plain = !hv;
        if (hv) begin
          phase_mid = PhaseDigit;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase
    if (plain && byte_i == CharPercent) begin
      phase_mid = PhasePercent;
    end
    phase_d = last_i ? PhaseIdle : phase_mid;
    held_char_d = held_char_q;
    held_nib_d = held_nib_q;
    if (phase_q == PhasePercent && hv) begin
      held_char_d = byte_i;
      held_nib_d = hex[NibbleW-1:0];
    end
  end

  always_comb begin
    logic [1:0] n;
    logic [LenW-1:0] cnt;
    logic [ByteW-1:0] b [MaxResults];
    logic [ByteW-1:0] emit_b;
    logic [1:0] k;
    dec_o = '0;
    n = '0;
    cnt = count_q;
    emit_b = '0;
    for (int i = 0; i < MaxResults; i++) begin
      b[i] = '0;
    end
    unique case (phase_q)
      PhaseDigit: begin
        if (hv) begin
          b[n] = {held_nib_q, hex[NibbleW-1:0]};
          n = n + 2'd1;
        end else begin
          b[n] = CharPercent;
          n = n + 2'd1;
          b[n] = held_char_q;
          n = n + 2'd1;
        end
      end
      PhasePercent: begin
        if (!hv) begin
          b[n] = CharPercent;
          n = n + 2'd1;
        end
      end
      default: begin
        n = n;
      end
    endcase
    if (plain && byte_i != CharPercent) begin
      emit_b = (byte_i == CharPlus) ? CharSpace : byte_i;
      b[n] = emit_b;
      n = n + 2'd1;
    end
    if (last_i && (phase_mid == PhasePercent || phase_mid == PhaseDigit)) begin
      b[n] = CharPercent;
      n = n + 2'd1;
    end
    if (last_i && phase_mid == PhaseDigit) begin
      b[n] = held_char_d;
      n = n + 2'd1;
    end
    for (int i = 0; i < MaxResults; i++) begin
      k = 2'(i);
      cnt = sat_inc(cnt);
      dec_o.res[i].data = b[i];
      dec_o.res[i].length = cnt;
      dec_o.res[i].last = last_i && (k + 2'd1 == n);
    end
    dec_o.count = n;
    if (n == 2'd0) begin
      count_d = count_q;
    end else begin
      count_d = dec_o.res[n - 2'd1].length;
    end
    if (last_i) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseIdle;
      held_char_q <= '0;
      held_nib_q <= '0;
      count_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      held_char_q <= held_char_d;
      held_nib_q <= held_nib_d;
      count_q <= count_d;
    end
  end

endmodule

### src/upd_out_buf.sv
// Result register that holds one item's results and hands them out one per transfer.
module upd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  upd_pkg::decode_t    dec_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic [15:0]         out_length_o
);
  import upd_pkg::*;

  decode_t buf_q;
  logic [1:0] rem_q;
  logic [1:0] rd_q;
  result_t cur;

  assign cur = buf_q.res[rd_q];
  assign out_valid_o = (rem_q != 2'd0);
  assign out_byte_o = cur.data;
  assign out_last_o = cur.last;
  assign out_length_o = cur.length;
  assign free_o = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ready_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= dec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      rd_q <= '0;
    end else if (load_i) begin
      rem_q <= dec_i.count;
      rd_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      rem_q <= rem_q - 2'd1;
      rd_q <= rd_q + 2'd1;
    end
  end

endmodule

### src/url_percent_decoder_top.sv
// Top level of the URL percent decoder: input register, escape decoder and result buffer.
// The decoder takes one encoded byte per transfer and returns zero to three decoded bytes
// per input byte, one per output transfer. A stream of bytes that each yield at most one
// result runs at one per cycle while out_ready_i is high; a byte yielding k results
// holds the result buffer until all k are transferred, which then sets the input rate.
// Each byte is registered in the input register, its results in the result buffer.
// The last result of a string carries out_last_o and the saturated decoded length.
module url_percent_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [15:0] out_length_o
);
  import upd_pkg::*;

  logic in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic in_last_q;
  logic buf_free;
  logic advance;
  decode_t dec;

  assign advance = in_valid_q && buf_free;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  upd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .dec_o     (dec)
  );

  upd_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .dec_i        (dec),
    .free_o       (buf_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_length_o (out_length_o)
  );

endmodule
